### hdl/crc32_pkg.sv
// ----------------------------------------------------------------------------
// crc32_pkg
// Shared types, constants and the byte update function of the CRC-32 stream
// checksum block.
// ----------------------------------------------------------------------------
package crc32_pkg;

   localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
   localparam int          QUEUE_DEPTH        = 2;
   localparam int          STRIDE_ABSORB      = 2;
   localparam int          POS_WIDTH          = 3;

   localparam logic [0:0]  CSR_STRIDE_MODE    = 1'b0;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [31:0] seed;
      logic        last_byte;
      logic        absorb;
   } crc32_item_type;

   function automatic logic [31:0] crc32_absorb_byte(input logic [31:0] crc,
                                                     input logic [7:0]  data);
      logic [31:0] acc;
      acc = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

### hdl/crc32_byte_stream_with_stride_mode.sv
// ----------------------------------------------------------------------------
// crc32_byte_stream_with_stride_mode
// Reflected CRC-32 over a byte stream with an optional 8-byte palette stride.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle through the combinational 8-bit update network, unless
// the queue is full or a final byte waits for the previous result to be taken.
// A final byte passes through the queue register and then the CRC output register.
// Reset: synchronous; CRC, held seed, position, stride mode and queue clear.
module crc32_byte_stream_with_stride_mode #(
   parameter int QueueDepth = crc32_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [31:0] req_seed,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_checksum,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                      stride_ff, stride_in;
   logic                      csr_write;
   logic                      queue_ready;
   logic                      push;
   crc32_pkg::crc32_item_type push_item;
   logic                      pop;
   logic                      pop_valid;
   crc32_pkg::crc32_item_type pop_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == crc32_pkg::CSR_STRIDE_MODE) ? {31'd0, stride_ff}
                                                                    : 32'd0;

   always_comb begin
      stride_in = stride_ff;
      if (csr_write && (csr_paddr[2] == crc32_pkg::CSR_STRIDE_MODE)) begin
         stride_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 1'b0;
      end else begin
         stride_ff <= stride_in;
      end
   end

   crc32_front u_front (
      .clock          (clock),
      .reset          (reset),
      .stride_mode    (stride_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_seed       (req_seed),
      .req_last_byte  (req_last_byte),
      .queue_ready    (queue_ready),
      .push           (push),
      .push_item      (push_item)
   );

   crc32_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   crc32_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (pop_valid),
      .item         (pop_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_checksum (rsp_checksum)
   );

endmodule

### hdl/crc32_front.sv
// ----------------------------------------------------------------------------
// crc32_front
// Accepts input transactions, tracks the position within the palette entry and
// marks each byte as absorbed or skipped before it enters the queue.
// ----------------------------------------------------------------------------
module crc32_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      stride_mode,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_first_byte,
   input  logic [31:0]               req_seed,
   input  logic                      req_last_byte,
   input  logic                      queue_ready,
   output logic                      push,
   output crc32_pkg::crc32_item_type push_item
);

   logic [crc32_pkg::POS_WIDTH-1:0] pos_ff;
   logic [crc32_pkg::POS_WIDTH-1:0] pos_in;
   logic [crc32_pkg::POS_WIDTH-1:0] pos_cur;

   assign req_ready = queue_ready;
   assign push      = req_valid & queue_ready;
   assign pos_cur   = req_first_byte ? '0 : pos_ff;

   always_comb begin
      push_item.data_byte  = req_data_byte;
      push_item.first_byte = req_first_byte;
      push_item.seed       = req_seed;
      push_item.last_byte  = req_last_byte;
      push_item.absorb     = !stride_mode ||
                             (pos_cur < crc32_pkg::POS_WIDTH'(crc32_pkg::STRIDE_ABSORB));
      pos_in = pos_ff;
      if (push) begin
         pos_in = pos_cur + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_plain_mode_absorbs: assert property (@(posedge clock) disable iff (reset)
      (push && !stride_mode) |-> push_item.absorb)
      else $error("byte skipped outside stride mode");

   a_first_absorbs: assert property (@(posedge clock) disable iff (reset)
      (push && req_first_byte) |-> push_item.absorb)
      else $error("first byte of a stream skipped");

endmodule

### hdl/crc32_queue.sv
// ----------------------------------------------------------------------------
// crc32_queue
// Short register queue that decouples the classifying front from the CRC back.
// ----------------------------------------------------------------------------
module crc32_queue #(
   parameter int Depth = crc32_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  crc32_pkg::crc32_item_type push_item,
   output logic                      push_ready,
   input  logic                      pop,
   output logic                      pop_valid,
   output crc32_pkg::crc32_item_type pop_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   crc32_pkg::crc32_item_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a transaction");

endmodule

### hdl/crc32_back.sv
// ----------------------------------------------------------------------------
// crc32_back
// Applies queued bytes to the CRC register and holds the finished checksum in
// an output register until the result transaction completes.
// ----------------------------------------------------------------------------
module crc32_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  crc32_pkg::crc32_item_type item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               rsp_checksum
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] seed_ff, seed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_checksum_ff, rsp_checksum_in;
   logic [31:0] crc_base;

   assign pop = item_valid && (!item.last_byte || !rsp_valid_ff || rsp_ready);

   always_comb begin
      crc_base        = item.first_byte ? item.seed : crc_ff;
      crc_in          = crc_ff;
      seed_in         = seed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_checksum_in = rsp_checksum_ff;
      if (pop) begin
         crc_in  = item.absorb ? crc32_pkg::crc32_absorb_byte(crc_base, item.data_byte)
                               : crc_base;
         seed_in = item.first_byte ? item.seed : seed_ff;
         if (item.last_byte) begin
            rsp_valid_in    = 1'b1;
            rsp_checksum_in = crc_in ^ seed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_checksum_ff <= rsp_checksum_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && item.last_byte))
      else $error("result raised without a final byte");

endmodule
